// File: hw/rtl/csim_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csim_pkg
// Shared widths, constants and types of the cosine similarity block.
// ----------------------------------------------------------------------------
package csim_pkg;

    localparam int DOT_BITS   = 42;   // signed running dot product
    localparam int NORM_BITS  = 41;   // unsigned running squared norms
    localparam int Q_FRAC     = 15;
    localparam int SIM_BITS   = 16;
    localparam int Q_BITS     = 16;   // magnitude search width
    localparam int K_BITS     = $clog2(Q_BITS);
    localparam int CHUNK_BITS = 21;   // partial product operand width
    localparam int SQ_BITS    = 2 * DOT_BITS;
    localparam int RHS_SHIFT  = 2 * Q_FRAC;
    localparam int SRCH_BITS  = 2 * NORM_BITS + 2 * Q_BITS + 1;

    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    localparam logic [SIM_BITS-1:0] SIM_MAX = {1'b0, {(SIM_BITS-1){1'b1}}};
    localparam logic [SIM_BITS-1:0] SIM_MIN = {1'b1, {(SIM_BITS-1){1'b0}}};

    // Finished sums of one vector pair
    typedef struct packed {
        logic signed [DOT_BITS-1:0]  dot;
        logic        [NORM_BITS-1:0] norm_a;
        logic        [NORM_BITS-1:0] norm_b;
        logic                        ovf;
    } t_snap;

    typedef struct packed {
        logic  vld;
        t_snap snap;
    } t_req;

endpackage

// File: hw/rtl/csim_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csim_in_if
// Element pair channel: valid/ready with a pair of signed elements.
// ----------------------------------------------------------------------------
interface csim_in_if #(
    parameter int ELEM_BITS = 16
) ();
    logic                        valid;
    logic                        ready;
    logic signed [ELEM_BITS-1:0] a_elem;
    logic signed [ELEM_BITS-1:0] b_elem;
    logic                        last;

    modport source (output valid, output a_elem, output b_elem, output last,
                    input ready);
    modport sink   (input valid, input a_elem, input b_elem, input last,
                    output ready);
endinterface

// File: hw/rtl/csim_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csim_out_if
// Result channel: valid/ready with similarity and status flags.
// ----------------------------------------------------------------------------
interface csim_out_if import csim_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SIM_BITS-1:0] similarity;
    logic                       zero_norm;
    logic                       overflow;

    modport source (output valid, output similarity, output zero_norm,
                    output overflow, input ready);
    modport sink   (input valid, input similarity, input zero_norm,
                    input overflow, output ready);
endinterface

// File: hw/rtl/csim_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csim_front
// Takes element pairs, forms products, keeps saturating running sums and
// hands the sums of a finished vector pair to the queue.
// ----------------------------------------------------------------------------
module csim_front import csim_pkg::*; #(
    parameter int ELEM_BITS = 16,
    parameter int MAX_DIM   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csim_in_if.sink     i_pair,
    input  logic        i_q_full,
    output t_req        o_push
);

    localparam int PROD_BITS = 2 * ELEM_BITS;
    localparam int ACC_BITS  = ((PROD_BITS > DOT_BITS) ? PROD_BITS : DOT_BITS) + 2;
    localparam int CNT_BITS  = $clog2(MAX_DIM + 1);

    logic                        r_s1_vld;
    logic                        r_s1_last;
    logic signed [PROD_BITS-1:0] r_prod_ab;
    logic signed [PROD_BITS-1:0] r_sq_a;
    logic signed [PROD_BITS-1:0] r_sq_b;

    logic signed [DOT_BITS-1:0]  r_dot, n_dot;
    logic        [NORM_BITS-1:0] r_na, n_na;
    logic        [NORM_BITS-1:0] r_nb, n_nb;
    logic        [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic                        r_ovf, n_ovf;

    logic signed [PROD_BITS-1:0] w_a_ext;
    logic signed [PROD_BITS-1:0] w_b_ext;
    logic                        w_in_acc;
    logic                        w_adv;
    logic                        w_room;
    logic signed [ACC_BITS-1:0]  w_dot_sum;
    logic        [ACC_BITS-1:0]  w_na_sum;
    logic        [ACC_BITS-1:0]  w_nb_sum;
    logic signed [DOT_BITS-1:0]  w_acc_dot;
    logic        [NORM_BITS-1:0] w_acc_na;
    logic        [NORM_BITS-1:0] w_acc_nb;
    logic        [ACC_BITS-DOT_BITS:0] w_dot_hi;

    assign w_a_ext  = PROD_BITS'(i_pair.a_elem);
    assign w_b_ext  = PROD_BITS'(i_pair.b_elem);

    // a last request waits in stage 1 until the queue has room
    assign w_adv    = r_s1_vld && (!r_s1_last || !i_q_full);
    assign i_pair.ready = !r_s1_vld || w_adv;
    assign w_in_acc = i_pair.valid && i_pair.ready;

    assign w_room    = (r_cnt != CNT_BITS'(MAX_DIM));
    assign w_dot_sum = ACC_BITS'(r_dot) + ACC_BITS'(r_prod_ab);
    assign w_na_sum  = ACC_BITS'(r_na) + ACC_BITS'($unsigned(r_sq_a));
    assign w_nb_sum  = ACC_BITS'(r_nb) + ACC_BITS'($unsigned(r_sq_b));
    assign w_dot_hi  = w_dot_sum[ACC_BITS-1:DOT_BITS-1];

    always_comb begin
        w_acc_dot = r_dot;
        w_acc_na  = r_na;
        w_acc_nb  = r_nb;
        if (w_room) begin
            if ((&w_dot_hi) || (~|w_dot_hi)) begin
                w_acc_dot = w_dot_sum[DOT_BITS-1:0];
            end else if (w_dot_sum[ACC_BITS-1]) begin
                w_acc_dot = {1'b1, {(DOT_BITS-1){1'b0}}};
            end else begin
                w_acc_dot = {1'b0, {(DOT_BITS-1){1'b1}}};
            end
            w_acc_na = (|w_na_sum[ACC_BITS-1:NORM_BITS]) ? '1 : w_na_sum[NORM_BITS-1:0];
            w_acc_nb = (|w_nb_sum[ACC_BITS-1:NORM_BITS]) ? '1 : w_nb_sum[NORM_BITS-1:0];
        end
    end

    always_comb begin
        n_dot = r_dot;
        n_na  = r_na;
        n_nb  = r_nb;
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (w_adv) begin
            if (r_s1_last) begin
                n_dot = '0;
                n_na  = '0;
                n_nb  = '0;
                n_cnt = '0;
                n_ovf = 1'b0;
            end else begin
                n_dot = w_acc_dot;
                n_na  = w_acc_na;
                n_nb  = w_acc_nb;
                n_cnt = w_room ? r_cnt + 1'b1 : r_cnt;
                n_ovf = r_ovf | !w_room;
            end
        end
    end

    assign o_push.vld         = r_s1_vld && r_s1_last && !i_q_full;
    assign o_push.snap.dot    = w_acc_dot;
    assign o_push.snap.norm_a = w_acc_na;
    assign o_push.snap.norm_b = w_acc_nb;
    assign o_push.snap.ovf    = r_ovf | !w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_dot    <= '0;
            r_na     <= '0;
            r_nb     <= '0;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (w_adv) begin
                r_s1_vld <= 1'b0;
            end
            r_dot <= n_dot;
            r_na  <= n_na;
            r_nb  <= n_nb;
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_last <= i_pair.last;
            r_prod_ab <= w_a_ext * w_b_ext;
            r_sq_a    <= w_a_ext * w_a_ext;
            r_sq_b    <= w_b_ext * w_b_ext;
        end
    end

endmodule

// File: hw/rtl/csim_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csim_fifo
// Short queue of finished sums between the accumulator and the divider.
// ----------------------------------------------------------------------------
module csim_fifo import csim_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_push,
    output logic o_full,
    input  logic i_pop,
    output t_req o_pull
);

    t_snap                  r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]  r_wr;
    logic [Q_PTR_BITS-1:0]  r_rd;
    logic [Q_CNT_BITS-1:0]  r_cnt;

    assign o_full      = (r_cnt == Q_CNT_BITS'(Q_DEPTH));
    assign o_pull.vld  = (r_cnt != '0);
    assign o_pull.snap = r_mem[r_rd];

    // depth is a power of two, pointers wrap by themselves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.vld) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push.vld, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld) begin
            r_mem[r_wr] <= i_push.snap;
        end
    end

endmodule

// File: hw/rtl/csim_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csim_back
// Turns one set of sums into a Q1.15 similarity: dot^2 and the norm product
// on a shared 21x21 multiplier, then a bit-serial quotient search.
// ----------------------------------------------------------------------------
module csim_back import csim_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_req        i_pull,
    output logic        o_pop,
    csim_out_if.source  o_result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_STEP = 3'd2;
    localparam logic [2:0] S_TEST = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]              r_state;

    logic [DOT_BITS-1:0]     r_mag;
    logic [NORM_BITS-1:0]    r_na;
    logic [NORM_BITS-1:0]    r_nb;
    logic                    r_neg;
    logic                    r_zero;
    logic                    r_ovf;

    logic [2:0]              r_mc;
    logic [2*CHUNK_BITS-1:0] r_pp;
    logic [1:0]              r_pp_sh;
    logic                    r_pp_tgt;
    logic                    r_pp_vld;
    logic [SQ_BITS-1:0]      r_p;
    logic [SQ_BITS-1:0]      r_sq;

    logic [K_BITS-1:0]       r_k;
    logic [Q_BITS-1:0]       r_q;
    logic [SRCH_BITS-1:0]    r_t;
    logic [SRCH_BITS-1:0]    r_u;
    logic [SRCH_BITS-1:0]    r_s;

    logic                    r_out_vld;
    logic [SIM_BITS-1:0]     r_sim;
    logic                    r_zero_o;
    logic                    r_ovf_o;

    logic                    w_load;
    logic [DOT_BITS-1:0]     w_x;
    logic [DOT_BITS-1:0]     w_y;
    logic [CHUNK_BITS-1:0]   w_xi;
    logic [CHUNK_BITS-1:0]   w_yi;
    logic [SQ_BITS-1:0]      w_pp_add;
    logic [SRCH_BITS-1:0]    w_p_ext;
    logic [SRCH_BITS-1:0]    w_cand;
    logic [SRCH_BITS-1:0]    w_rhs;
    logic [SIM_BITS-1:0]     w_sim;
    logic                    w_in_neg;

    assign o_pop  = (r_state == S_IDLE) && i_pull.vld;
    assign w_load = (r_state == S_DONE) && (!r_out_vld || o_result.ready);
    assign w_in_neg = i_pull.snap.dot[DOT_BITS-1];

    // first four partial products give norm_a * norm_b, the last four dot^2
    assign w_x  = r_mc[2] ? r_mag : {1'b0, r_na};
    assign w_y  = r_mc[2] ? r_mag : {1'b0, r_nb};
    assign w_xi = r_mc[1] ? w_x[2*CHUNK_BITS-1:CHUNK_BITS] : w_x[CHUNK_BITS-1:0];
    assign w_yi = r_mc[0] ? w_y[2*CHUNK_BITS-1:CHUNK_BITS] : w_y[CHUNK_BITS-1:0];

    always_comb begin
        case (r_pp_sh)
            2'd0:    w_pp_add = SQ_BITS'(r_pp);
            2'd1:    w_pp_add = SQ_BITS'(r_pp) << CHUNK_BITS;
            2'd2:    w_pp_add = SQ_BITS'(r_pp) << (2 * CHUNK_BITS);
            default: w_pp_add = '0;
        endcase
    end

    // search keeps t = q*q*P and u = q*P, so a trial bit costs only adds
    assign w_p_ext = SRCH_BITS'(r_p);
    assign w_cand  = r_t + r_s;
    assign w_rhs   = SRCH_BITS'({r_sq, {RHS_SHIFT{1'b0}}});

    always_comb begin
        if (r_neg) begin
            w_sim = (r_q > Q_BITS'(SIM_MAX)) ? SIM_MIN : SIM_BITS'(Q_BITS'(0) - r_q);
        end else begin
            w_sim = (r_q > Q_BITS'(SIM_MAX)) ? SIM_MAX : SIM_BITS'(r_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pp_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_pp_vld <= (r_state == S_MUL);
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_pull.vld) begin
                        if ((i_pull.snap.norm_a == '0) || (i_pull.snap.norm_b == '0)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    if (r_mc == '1) begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_state <= S_TEST;
                end
                S_TEST: begin
                    r_state <= (r_k == '0) ? S_DONE : S_STEP;
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        // last partial product lands during the first search step; the
        // square is not read before the test step
        if (r_pp_vld) begin
            if (r_pp_tgt) begin
                r_sq <= r_sq + w_pp_add;
            end else begin
                r_p <= r_p + w_pp_add;
            end
        end
        case (r_state)
            S_IDLE: begin
                if (i_pull.vld) begin
                    r_mag  <= w_in_neg ? DOT_BITS'(0) - i_pull.snap.dot : i_pull.snap.dot;
                    r_na   <= i_pull.snap.norm_a;
                    r_nb   <= i_pull.snap.norm_b;
                    r_neg  <= w_in_neg;
                    r_zero <= (i_pull.snap.norm_a == '0) || (i_pull.snap.norm_b == '0);
                    r_ovf  <= i_pull.snap.ovf;
                    r_p    <= '0;
                    r_sq   <= '0;
                    r_mc   <= '0;
                    r_q    <= '0;
                end
            end
            S_MUL: begin
                r_mc     <= r_mc + 1'b1;
                r_pp     <= w_xi * w_yi;
                r_pp_sh  <= {1'b0, r_mc[1]} + {1'b0, r_mc[0]};
                r_pp_tgt <= r_mc[2];
                if (r_mc == '1) begin
                    r_k <= '1;
                    r_t <= '0;
                    r_u <= '0;
                end
            end
            S_STEP: begin
                r_s <= (r_u << ({1'b0, r_k} + 1'b1)) + (w_p_ext << {r_k, 1'b0});
            end
            S_TEST: begin
                if (w_cand <= w_rhs) begin
                    r_t      <= w_cand;
                    r_u      <= r_u + (w_p_ext << r_k);
                    r_q[r_k] <= 1'b1;
                end
                r_k <= r_k - 1'b1;
            end
            S_DONE: begin
                if (w_load) begin
                    r_sim    <= w_sim;
                    r_zero_o <= r_zero;
                    r_ovf_o  <= r_ovf;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.valid      = r_out_vld;
    assign o_result.similarity = r_sim;
    assign o_result.zero_norm  = r_zero_o;
    assign o_result.overflow   = r_ovf_o;

endmodule

// File: hw/rtl/cosine_similarity.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity
// Streaming cosine similarity of two signed vectors, Q1.15 result.
// ----------------------------------------------------------------------------
// Usage:
//   i_pair carries one element pair per request (a_elem, b_elem, last).
//   Pairs are taken one per cycle unless stalled; last closes the vector pair.
//   o_result carries one request per vector pair: similarity (Q1.15,
//   truncated toward zero, 32767 for exactly 1.0), zero_norm and overflow.
//   Pairs beyond MAX_DIM are dropped from the sums and raise overflow.
// Timing:
//   The accumulator adds one pair per cycle unless stalled.
//   Each closed vector pair then holds the back end while it is taken
//   from the queue, multiplied out on the shared 21x21 multiplier,
//   searched one quotient bit at a time over 16 bits with a step and a
//   test state per bit, and its result loaded; a zero norm goes from the
//   queue straight to the result.
//   A two-entry queue lets the next vectors stream in during that work.
// Reset and stall:
//   Synchronous active-low reset clears the sums, queue and result valid.
//   If o_result is stalled the back end holds its result; the queue fills
//   and then i_pair.ready drops on the next last pair.
// ----------------------------------------------------------------------------
module cosine_similarity import csim_pkg::*; #(
    parameter int ELEM_BITS = 16,
    parameter int MAX_DIM   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csim_in_if.sink     i_pair,
    csim_out_if.source  o_result
);

    t_req w_push;
    t_req w_pull;
    logic w_q_full;
    logic w_pop;

    csim_front #(
        .ELEM_BITS (ELEM_BITS),
        .MAX_DIM   (MAX_DIM)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pair   (i_pair),
        .i_q_full (w_q_full),
        .o_push   (w_push)
    );

    csim_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_pull  (w_pull)
    );

    csim_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pull   (w_pull),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.vld |-> !w_q_full)
        else $error("push into full queue");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_pull.vld)
        else $error("pop from empty queue");

    a_dot_implies_norms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.vld && (w_push.snap.dot != '0)) |->
            ((w_push.snap.norm_a != '0) && (w_push.snap.norm_b != '0)))
        else $error("nonzero dot product with a zero norm");

    a_back_busy_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> !w_pop)
        else $error("back end popped twice in a row");
`endif

endmodule
